>>> rtl/lzwd_pkg.sv
package lzwd_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_PULL = 2'd1,
    CMD_END  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_BYTE   = 3'd0,
    ST_TAKEN  = 3'd1,
    ST_NEED   = 3'd2,
    ST_END    = 3'd3,
    ST_REFUSE = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_MAX_BITS    = 2'd0,
    CFG_BLOCK_MODE  = 2'd1,
    CFG_PASSTHROUGH = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_FIRST       = 2'd0,
    PH_NORMAL      = 2'd1,
    PH_AFTER_CLEAR = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SIMPLE,
    OP_FIN,
    OP_START,
    OP_RELOAD,
    OP_NEED,
    OP_LOAD,
    OP_EXTRACT,
    OP_FIRST,
    OP_CLEAR,
    OP_KWK,
    OP_WALK_PUSH,
    OP_FINISH,
    OP_POP_RD,
    OP_RESP_STACK
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP,
    S_POP_OUT,
    S_RELOAD,
    S_LOADCHK,
    S_EXTRACT,
    S_DISPATCH,
    S_WALK_RD,
    S_WALK_DATA
  } state_e;

  typedef struct packed {
    logic stack_empty;
    logic finished;
    logic passthrough;
    logic wait_input;
    logic group_empty;
    logic phase_first;
    logic is_clear;
    logic walk_more;
  } dp_stat_t;

  localparam logic [4:0] InitBits = 5'd9;
  localparam logic [4:0] GroupMax = 5'd16;

endpackage

>>> rtl/lzwd_ctrl.sv
module lzwd_ctrl
  import lzwd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_fire_i,
  input  logic [1:0] in_cmd_i,
  input  dp_stat_t stat_i,
  output op_e      op_o,
  output logic     idle_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    idle_o  = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_fire_i) begin
          if (in_cmd_i == CMD_PULL && !stat_i.passthrough) begin
            if (!stat_i.stack_empty) begin
              state_d = S_POP;
            end else if (stat_i.finished) begin
              op_o = OP_FIN;
            end else begin
              op_o    = OP_START;
              state_d = S_RELOAD;
            end
          end else begin
            op_o = OP_SIMPLE;
          end
        end
      end
      S_POP: begin
        op_o    = OP_POP_RD;
        state_d = S_POP_OUT;
      end
      S_POP_OUT: begin
        op_o    = OP_RESP_STACK;
        state_d = S_IDLE;
      end
      S_RELOAD: begin
        op_o    = OP_RELOAD;
        state_d = S_LOADCHK;
      end
      S_LOADCHK: begin
        if (stat_i.wait_input) begin
          op_o    = OP_NEED;
          state_d = S_IDLE;
        end else if (stat_i.group_empty) begin
          op_o    = OP_FIN;
          state_d = S_IDLE;
        end else begin
          op_o    = OP_LOAD;
          state_d = S_EXTRACT;
        end
      end
      S_EXTRACT: begin
        op_o    = OP_EXTRACT;
        state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (stat_i.phase_first) begin
          op_o    = OP_FIRST;
          state_d = S_IDLE;
        end else if (stat_i.is_clear) begin
          op_o    = OP_CLEAR;
          state_d = S_RELOAD;
        end else begin
          op_o    = OP_KWK;
          state_d = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        state_d = S_WALK_DATA;
      end
      S_WALK_DATA: begin
        if (stat_i.walk_more) begin
          op_o    = OP_WALK_PUSH;
          state_d = S_WALK_RD;
        end else begin
          op_o    = OP_FINISH;
          state_d = S_POP;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> rtl/lzwd_dp.sv
module lzwd_dp
  import lzwd_pkg::*;
#(
  parameter int TABLE_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  op_e        op_i,
  input  logic [1:0] in_cmd_i,
  input  logic [7:0] in_byte_i,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [4:0] cfg_data_i,
  input  logic       out_take_i,
  output dp_stat_t   stat_o,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic [2:0] out_status_o
);

  localparam int Aw   = TABLE_BITS;
  localparam int Size = 2 ** TABLE_BITS;

  logic [Aw-1:0] prefix_mem [Size];
  logic [7:0]    suffix_mem [Size];
  logic [7:0]    stack_mem  [Size];

  logic [4:0] max_bits_q;
  logic       bm_q, pt_q;

  logic [127:0] vec_q, vec_d;
  logic [127:0] ext_q, ext_d;
  logic [4:0]   fill_q, fill_d;
  logic         loading_q, loading_d, ended_q, ended_d;
  logic         finished_q, finished_d, started_q, started_d;
  logic         clear_q, clear_d;
  phase_e       phase_q, phase_d;
  logic [4:0]   cw_q, cw_d;
  logic [Aw:0]  limit_q, limit_d, nfc_q, nfc_d, sp_q, sp_d;
  logic [Aw-1:0] prev_q, prev_d, code_q, code_d, walk_q, walk_d;
  logic [7:0]   fc_q, fc_d;
  logic [7:0]   bo_q, bo_d;
  logic signed [8:0] gb_q, gb_d;
  logic         out_valid_q, out_valid_d;
  logic [7:0]   out_byte_q, out_byte_d;
  logic [2:0]   out_status_q, out_status_d;

  logic [Aw-1:0] pre_rd_q;
  logic [7:0]    suf_rd_q, stk_rd_q;
  logic          stk_we, tab_we;
  logic [7:0]    stk_wdata;
  logic [Aw-1:0] stk_raddr;

  logic [4:0]  mb, cw_n;
  logic        walk_lo;
  logic [15:0] mask16;
  logic [7:0]  walk_suf;

  always_comb begin
    if (max_bits_q < InitBits)              mb = InitBits;
    else if (max_bits_q > 5'(TABLE_BITS))   mb = 5'(TABLE_BITS);
    else                                    mb = max_bits_q;
  end

  assign walk_lo  = (walk_q[Aw-1:8] == '0);
  assign walk_suf = walk_lo ? walk_q[7:0] : suf_rd_q;
  assign mask16   = 16'((17'd1 << cw_q) - 17'd1);

  assign stat_o.stack_empty = (sp_q == '0);
  assign stat_o.finished    = finished_q;
  assign stat_o.passthrough = pt_q;
  assign stat_o.wait_input  = loading_q && (fill_q < cw_q) && !ended_q;
  assign stat_o.group_empty = loading_q && (fill_q == '0);
  assign stat_o.phase_first = (phase_q == PH_FIRST);
  assign stat_o.is_clear    = (phase_q == PH_NORMAL) && bm_q &&
                              (code_q == Aw'(256));
  assign stat_o.walk_more   = !walk_lo && (sp_q < (Aw+1)'(Size - 1));

  always_comb begin
    vec_d = vec_q; ext_d = ext_q; fill_d = fill_q; loading_d = loading_q;
    ended_d = ended_q;
    finished_d = finished_q; started_d = started_q; clear_d = clear_q;
    phase_d = phase_q; cw_d = cw_q; limit_d = limit_q; nfc_d = nfc_q;
    sp_d = sp_q; prev_d = prev_q; code_d = code_q; walk_d = walk_q;
    fc_d = fc_q; bo_d = bo_q; gb_d = gb_q;
    out_valid_d  = out_valid_q && !out_take_i;
    out_byte_d   = out_byte_q;
    out_status_d = out_status_q;
    stk_we = 1'b0; stk_wdata = fc_q; tab_we = 1'b0;
    stk_raddr = Aw'(sp_q - (Aw+1)'(1));
    cw_n = cw_q;
    case (op_i)
      OP_SIMPLE: begin
        out_valid_d = 1'b1;
        out_byte_d  = 8'd0;
        case (in_cmd_i)
          CMD_PUSH: begin
            if (ended_q) begin
              out_status_d = ST_REFUSE;
            end else if (pt_q) begin
              if (fill_q != '0) out_status_d = ST_REFUSE;
              else begin
                vec_d[7:0] = in_byte_i; fill_d = 5'd1; out_status_d = ST_TAKEN;
              end
            end else if (!loading_q || fill_q >= cw_q || fill_q >= GroupMax) begin
              out_status_d = ST_REFUSE;
            end else begin
              vec_d[{fill_q[3:0], 3'b000} +: 8] = in_byte_i;
              fill_d = fill_q + 5'd1;
              out_status_d = ST_TAKEN;
            end
          end
          CMD_PULL: begin
            if (fill_q != '0) begin
              out_byte_d = vec_q[7:0]; fill_d = '0; out_status_d = ST_BYTE;
            end else begin
              out_status_d = ended_q ? ST_END : ST_NEED;
            end
          end
          CMD_END: begin
            ended_d = 1'b1; out_status_d = ST_TAKEN;
          end
          default: out_status_d = ST_REFUSE;
        endcase
      end
      OP_FIN: begin
        finished_d = 1'b1;
        out_valid_d = 1'b1; out_byte_d = 8'd0; out_status_d = ST_END;
      end
      OP_NEED: begin
        out_valid_d = 1'b1; out_byte_d = 8'd0; out_status_d = ST_NEED;
      end
      OP_START: begin
        if (!started_q) begin
          nfc_d = bm_q ? (Aw+1)'(257) : (Aw+1)'(256);
          started_d = 1'b1;
          phase_d = PH_FIRST;
        end
      end
      OP_RELOAD: begin
        if (!loading_q && (clear_q || gb_q[8] || bo_q >= gb_q[7:0] ||
                           nfc_q > limit_q)) begin
          if (nfc_q > limit_q) begin
            if (cw_q < mb) cw_n = cw_q + 5'd1;
            cw_d = cw_n;
            if (cw_n >= mb) limit_d = (Aw+1)'(1) << mb;
            else            limit_d = ((Aw+1)'(1) << cw_n) - (Aw+1)'(1);
          end
          if (clear_q) begin
            cw_d = InitBits;
            limit_d = (Aw+1)'(511);
            clear_d = 1'b0;
          end
          loading_d = 1'b1;
          fill_d = '0;
          vec_d = '0;
        end
      end
      OP_LOAD: begin
        if (loading_q) begin
          gb_d = $signed({1'b0, fill_q, 3'b000}) - $signed({4'b0, cw_q - 5'd1});
          bo_d = '0;
          // the group buffer stays intact, codes are shifted out of a copy
          ext_d = vec_q;
          loading_d = 1'b0;
        end
      end
      OP_EXTRACT: begin
        code_d = Aw'(ext_q[15:0] & mask16);
        ext_d  = ext_q >> cw_q;
        bo_d   = bo_q + 8'(cw_q);
      end
      OP_FIRST: begin
        fc_d = code_q[7:0];
        prev_d = code_q;
        phase_d = PH_NORMAL;
        out_valid_d = 1'b1; out_byte_d = code_q[7:0]; out_status_d = ST_BYTE;
      end
      OP_CLEAR: begin
        clear_d = 1'b1;
        nfc_d = (Aw+1)'(256);
        phase_d = PH_AFTER_CLEAR;
      end
      OP_KWK: begin
        phase_d = PH_NORMAL;
        // code not yet in the table: it ends with its own first character
        if ({1'b0, code_q} >= nfc_q) begin
          stk_we = !sp_q[Aw]; stk_wdata = fc_q;
          if (!sp_q[Aw]) sp_d = sp_q + (Aw+1)'(1);
          walk_d = prev_q;
        end else begin
          walk_d = code_q;
        end
      end
      OP_WALK_PUSH: begin
        stk_we = !sp_q[Aw]; stk_wdata = walk_suf;
        if (!sp_q[Aw]) sp_d = sp_q + (Aw+1)'(1);
        walk_d = pre_rd_q;
      end
      OP_FINISH: begin
        fc_d = walk_suf;
        stk_we = !sp_q[Aw]; stk_wdata = walk_suf;
        if (!sp_q[Aw]) sp_d = sp_q + (Aw+1)'(1);
        if (nfc_q < ((Aw+1)'(1) << mb)) begin
          tab_we = 1'b1;
          nfc_d = nfc_q + (Aw+1)'(1);
        end
        prev_d = code_q;
      end
      OP_POP_RD: begin
        sp_d = sp_q - (Aw+1)'(1);
      end
      OP_RESP_STACK: begin
        out_valid_d = 1'b1; out_byte_d = stk_rd_q; out_status_d = ST_BYTE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stack_mem[sp_q[Aw-1:0]] <= stk_wdata;
    stk_rd_q <= stack_mem[stk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      prefix_mem[nfc_q[Aw-1:0]] <= prev_q;
      suffix_mem[nfc_q[Aw-1:0]] <= walk_suf;
    end
    pre_rd_q <= prefix_mem[walk_q];
    suf_rd_q <= suffix_mem[walk_q];
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d; code_q <= code_d; walk_q <= walk_d;
    fc_q <= fc_d; gb_q <= gb_d; out_byte_q <= out_byte_d;
    out_status_q <= out_status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bits_q <= 5'd16; bm_q <= 1'b1; pt_q <= 1'b0;
      vec_q <= '0; ext_q <= '0;
      fill_q <= '0; loading_q <= 1'b1; ended_q <= 1'b0; finished_q <= 1'b0;
      started_q <= 1'b0; clear_q <= 1'b0; phase_q <= PH_FIRST;
      cw_q <= InitBits; limit_q <= (Aw+1)'(511); nfc_q <= (Aw+1)'(257);
      sp_q <= '0; bo_q <= '0; out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MAX_BITS:    max_bits_q <= cfg_data_i;
          CFG_BLOCK_MODE:  bm_q <= cfg_data_i[0];
          CFG_PASSTHROUGH: pt_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      vec_q <= vec_d; ext_q <= ext_d;
      fill_q <= fill_d; loading_q <= loading_d; ended_q <= ended_d;
      finished_q <= finished_d; started_q <= started_d; clear_q <= clear_d;
      phase_q <= phase_d; cw_q <= cw_d; limit_q <= limit_d; nfc_q <= nfc_d;
      sp_q <= sp_d; bo_q <= bo_d; out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign out_status_o = out_status_q;

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= (Aw+1)'(Size)) else $error("stack pointer out of range");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= GroupMax) else $error("group fill out of range");
  a_cw_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cw_q >= InitBits && cw_q <= 5'(TABLE_BITS)) else $error("code width out of range");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i == OP_POP_RD |-> sp_q != '0) else $error("pop from empty stack");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_RESP_STACK || op_i == OP_FIRST || op_i == OP_SIMPLE) |-> !out_valid_q)
    else $error("response overwrites pending result");

endmodule

>>> rtl/lzw_compress_decoder.sv
// sequence: push, end and passthrough requests are answered from the idle state; a pull
// served from the expand stack reads the stack, then answers; a pull that decodes a new
// code extracts it, then walks its prefix chain (a prefix/suffix table read per character)
// throughput: one request at a time, the next is taken once the result has been taken
// reset: async active low; control state cleared, tables need no clearing pass
module lzw_compress_decoder
  import lzwd_pkg::*;
#(
  parameter int TABLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
  input  logic [1:0]  s_axis_tuser,  // [1:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
  output logic [2:0]  m_axis_tuser,  // [2:0] status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i
);

  op_e      op;
  dp_stat_t stat;
  logic     idle, in_fire;

  assign s_axis_tready = idle && !m_axis_tvalid;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  lzwd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .in_cmd_i  (s_axis_tuser),
    .stat_i    (stat),
    .op_o      (op),
    .idle_o    (idle)
  );

  lzwd_dp #(.TABLE_BITS(TABLE_BITS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .in_cmd_i     (s_axis_tuser),
    .in_byte_i    (s_axis_tdata),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_take_i   (m_axis_tready),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid),
    .out_byte_o   (m_axis_tdata),
    .out_status_o (m_axis_tuser)
  );

endmodule

>>> dv/lzwd_checker.sv
`timescale 1ns / 1ps

module lzwd_checker
  import lzwd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  input  logic       s_ready_i,
  input  logic [7:0] s_data_i,
  input  logic [1:0] s_user_i,
  input  logic       m_valid_i,
  input  logic       m_ready_i,
  input  logic [7:0] m_data_i,
  input  logic [2:0] m_user_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [1:0] cfg_index_i,
  input  logic [4:0] cfg_data_i,
  output int         errors_o,
  output int         pending_o
);

  localparam int unsigned TableSize = 65536;
  localparam int unsigned ClearCode = 256;

  typedef struct {
    logic [7:0] data;
    status_e    status;
  } reply_t;

  reply_t reply_q[$];

  bit [15:0]   prefix_mem [TableSize];
  bit [7:0]    suffix_mem [TableSize];
  bit [7:0]    stack_mem  [TableSize];
  bit [7:0]    grp_mem    [16];
  int unsigned stack_n, grp_fill, cur_width, width_lim, free_code, prev_code, bit_pos;
  int          grp_bits;
  bit [7:0]    first_byte;
  bit          clr_pend, loading, in_ended, finished, started;
  phase_e      phase;
  bit [4:0]    max_bits;
  bit          block_mode, passthrough;

  function automatic int unsigned width_cap();
    if (max_bits < InitBits) return InitBits;
    if (max_bits > 16) return 16;
    return max_bits;
  endfunction

  function automatic int unsigned grp_at(int unsigned i);
    return (i < 16) ? grp_mem[i] : 0;
  endfunction

  // 0 code ready, 1 need input, 2 end of data
  function automatic int fetch_code(output int unsigned code);
    int unsigned cap, idx, w;
    cap  = width_cap();
    code = 0;
    if (!loading) begin
      if (clr_pend || int'(bit_pos) >= grp_bits || free_code > width_lim) begin
        if (free_code > width_lim) begin
          if (cur_width < cap) cur_width++;
          width_lim = (cur_width >= cap) ? (1 << cap) : (1 << cur_width) - 1;
        end
        if (clr_pend) begin
          cur_width = InitBits;
          width_lim = (1 << InitBits) - 1;
          clr_pend  = 0;
        end
        loading  = 1;
        grp_fill = 0;
        foreach (grp_mem[i]) grp_mem[i] = 0;
      end
    end
    if (loading) begin
      if (grp_fill < cur_width && !in_ended) return 1;
      if (grp_fill == 0) return 2;
      grp_bits = int'(grp_fill) * 8 - int'(cur_width) + 1;
      bit_pos  = 0;
      loading  = 0;
    end
    idx  = bit_pos >> 3;
    w    = grp_at(idx) | (grp_at(idx + 1) << 8) | (grp_at(idx + 2) << 16);
    code = (w >> (bit_pos & 7)) & ((1 << cur_width) - 1);
    bit_pos += cur_width;
    return 0;
  endfunction

  function automatic void stack_push(bit [7:0] b);
    if (stack_n < TableSize) begin
      stack_mem[stack_n] = b;
      stack_n++;
    end
  endfunction

  function automatic void expand_code(int unsigned code);
    int unsigned incode;
    incode = code;
    if (code >= free_code) begin
      stack_push(first_byte);
      code = prev_code;
    end
    code &= TableSize - 1;
    while (code >= 256 && stack_n < TableSize - 1) begin
      stack_push(suffix_mem[code]);
      code = prefix_mem[code];
    end
    first_byte = suffix_mem[code];
    stack_push(first_byte);
    if (free_code < (1 << width_cap())) begin
      prefix_mem[free_code] = prev_code[15:0];
      suffix_mem[free_code] = first_byte;
      free_code++;
    end
    prev_code = incode;
  endfunction

  function automatic status_e pull_byte(output bit [7:0] b);
    int unsigned c;
    int          r;
    b = 0;
    if (stack_n > 0) begin
      stack_n--;
      b = stack_mem[stack_n];
      return ST_BYTE;
    end
    if (finished) return ST_END;
    if (!started) begin
      for (int i = 0; i < 256; i++) begin
        prefix_mem[i] = 0;
        suffix_mem[i] = i[7:0];
      end
      free_code = block_mode ? 257 : 256;
      started   = 1;
      phase     = PH_FIRST;
    end
    while (1) begin
      r = fetch_code(c);
      if (r == 1) return ST_NEED;
      if (r == 2) begin
        finished = 1;
        return ST_END;
      end
      if (phase == PH_FIRST) begin
        first_byte = c[7:0];
        prev_code  = c;
        phase      = PH_NORMAL;
        b          = first_byte;
        return ST_BYTE;
      end
      if (phase == PH_NORMAL && c == ClearCode && block_mode) begin
        clr_pend  = 1;
        free_code = 256;
        phase     = PH_AFTER_CLEAR;
        continue;
      end
      phase = PH_NORMAL;
      expand_code(c);
      stack_n--;
      b = stack_mem[stack_n];
      return ST_BYTE;
    end
    return ST_END;
  endfunction

  function automatic reply_t predict_reply(logic [1:0] cmd, logic [7:0] b);
    reply_t   r;
    bit [7:0] ob;
    r.data = 0;
    case (cmd)
      CMD_PUSH: begin
        if (in_ended) begin
          r.status = ST_REFUSE;
        end else if (passthrough) begin
          if (grp_fill >= 1) begin
            r.status = ST_REFUSE;
          end else begin
            grp_mem[0] = b;
            grp_fill   = 1;
            r.status   = ST_TAKEN;
          end
        end else if (!loading || grp_fill >= cur_width || grp_fill >= 16) begin
          r.status = ST_REFUSE;
        end else begin
          grp_mem[grp_fill] = b;
          grp_fill++;
          r.status = ST_TAKEN;
        end
      end
      CMD_PULL: begin
        if (passthrough) begin
          if (grp_fill > 0) begin
            r.data   = grp_mem[0];
            grp_fill = 0;
            r.status = ST_BYTE;
          end else begin
            r.status = in_ended ? ST_END : ST_NEED;
          end
        end else begin
          r.status = pull_byte(ob);
          if (r.status == ST_BYTE) r.data = ob;
        end
      end
      CMD_END: begin
        in_ended = 1;
        r.status = ST_TAKEN;
      end
      default: r.status = ST_REFUSE;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t exp_r;
    if (!rst_ni) begin
      reply_q.delete();
      stack_n     = 0;
      grp_fill    = 0;
      cur_width   = InitBits;
      width_lim   = (1 << InitBits) - 1;
      free_code   = 257;
      prev_code   = 0;
      first_byte  = 0;
      bit_pos     = 0;
      grp_bits    = 0;
      clr_pend    = 0;
      loading     = 1;
      in_ended    = 0;
      finished    = 0;
      started     = 0;
      phase       = PH_FIRST;
      max_bits    = 16;
      block_mode  = 1;
      passthrough = 0;
      errors_o    = 0;
      pending_o   = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MAX_BITS:    max_bits    = cfg_data_i;
          CFG_BLOCK_MODE:  block_mode  = cfg_data_i[0];
          CFG_PASSTHROUGH: passthrough = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) reply_q.push_back(predict_reply(s_user_i, s_data_i));
      if (m_valid_i && m_ready_i) begin
        if (reply_q.size() == 0) begin
          report_mismatch($sformatf("reply with none pending: data %0h status %0d",
                                    m_data_i, m_user_i));
        end else begin
          exp_r = reply_q.pop_front();
          if (m_user_i != exp_r.status)
            report_mismatch($sformatf("status %0d, expected %0d", m_user_i, exp_r.status));
          if (m_data_i != exp_r.data)
            report_mismatch($sformatf("out byte %0h, expected %0h", m_data_i, exp_r.data));
        end
      end
      pending_o = reply_q.size();
    end
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lzwd_pkg::*;

  localparam int unsigned ClearCode = 256;
  localparam int          StreamCodes = 450;

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       s_axis_tvalid = 0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 0;
  logic [1:0] s_axis_tuser = 0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 0;
  logic [7:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic       cfg_valid_i = 0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = 0;
  logic [4:0] cfg_data_i = 0;

  int      errors, pending;
  int      inflight, need_cnt, need_done;
  status_e last_st;
  int      snd_idle_pct, rcv_stall_pct;
  int      hold_ask = 0;
  int      hold_done = 0;
  int      hold_left = 0;

  // mirror of the decoder's code bookkeeping, used to build a legal stream
  int unsigned g_nf, g_w, g_lim, g_mb, g_gw;
  bit          g_clrp, g_first, g_after, g_force_clr;
  int          g_codes;
  int unsigned grp_codes[$];
  logic [7:0]  grp_bytes[$];
  int unsigned grp_len[$];

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  lzw_compress_decoder u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  lzwd_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_i  (s_axis_tready),
    .s_data_i   (s_axis_tdata),
    .s_user_i   (s_axis_tuser),
    .m_valid_i  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_i   (m_axis_tdata),
    .m_user_i   (m_axis_tuser),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_i(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight <= 0;
      need_cnt <= 0;
      last_st  <= ST_TAKEN;
    end else begin
      inflight <= inflight + int'(s_axis_tvalid && s_axis_tready)
                           - int'(m_axis_tvalid && m_axis_tready);
      if (m_axis_tvalid && m_axis_tready) begin
        last_st <= status_e'(m_axis_tuser);
        if (m_axis_tuser == ST_NEED) need_cnt <= need_cnt + 1;
      end
    end
  end

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_ask != hold_done) begin
      hold_done     <= hold_ask;
      hold_left     <= 400;
      m_axis_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("[lzw_compress_decoder] ERROR");
    $finish;
  end

  function automatic void set_idling(int m);
    case (m)
      0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
      1: begin snd_idle_pct = 79; rcv_stall_pct = 0;  end
      2: begin snd_idle_pct = 0;  rcv_stall_pct = 79; end
      default: begin snd_idle_pct = 33; rcv_stall_pct = 33; end
    endcase
  endfunction

  function automatic void close_group();
    logic [127:0] v;
    v = '0;
    foreach (grp_codes[k]) v |= 128'(grp_codes[k]) << (k * g_gw);
    for (int i = 0; i < int'(g_gw); i++) grp_bytes.push_back(v[i*8 +: 8]);
    grp_len.push_back(g_gw);
    grp_codes.delete();
    if (g_nf > g_lim) begin
      if (g_w < g_mb) g_w++;
      g_lim = (g_w >= g_mb) ? (1 << g_mb) : (1 << g_w) - 1;
    end
    if (g_clrp) begin
      g_w    = InitBits;
      g_lim  = (1 << InitBits) - 1;
      g_clrp = 0;
    end
    g_gw = g_w;
  endfunction

  // next code of the stream: literals, known strings, the KwKwK case, codes past the next free one, clears
  function automatic void gen_code();
    int unsigned c, r;
    bit          clr, clr_ok;
    clr = 0;
    if (!g_first && (grp_codes.size() == 8 || g_clrp || g_nf > g_lim)) close_group();
    clr_ok = (g_codes < 60) || (g_nf == (1 << g_mb));
    r = $urandom_range(99);
    if (g_first) begin
      // corrupt first code, cleared right away
      c           = 300;
      g_first     = 0;
      g_force_clr = 1;
    end else if (g_after) begin
      c = $urandom_range(255);
    end else if (g_force_clr || (clr_ok && $urandom_range(19) == 0)) begin
      c           = ClearCode;
      clr         = 1;
      g_force_clr = 0;
    end else if (r < 6 && g_nf < (1 << g_w)) begin
      c = g_nf;
    end else if (r < 9 && clr_ok && g_nf + 1 < (1 << g_w)) begin
      c           = $urandom_range((1 << g_w) - 1, g_nf + 1);
      g_force_clr = 1;
    end else if (r < 35 && g_nf > 257) begin
      c = $urandom_range(g_nf - 1, 257);
    end else begin
      c = $urandom_range(255);
    end
    if (clr) begin
      g_clrp  = 1;
      g_nf    = 256;
      g_after = 1;
    end else if (g_codes > 0) begin
      g_after = 0;
      if (g_nf < (1 << g_mb)) g_nf++;
    end
    grp_codes.push_back(c);
    g_codes++;
  endfunction

  // entered and left on a rising edge
  task automatic send_req(cmd_e cmd, logic [7:0] b);
    if ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle_pct);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= b;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid <= 0;
    do @(posedge clk_i); while (inflight != 0);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [4:0] v);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic take_group(output int unsigned n);
    while (grp_len.size() == 0) gen_code();
    n = grp_len.pop_front();
  endtask

  initial begin
    int unsigned n, k;
    int          r;
    bit          held;
    g_nf = 257; g_w = InitBits; g_lim = 511; g_mb = 10; g_gw = InitBits;
    g_first = 1; g_clrp = 0; g_after = 0; g_force_clr = 0; g_codes = 0;
    need_done = 0; held = 0;
    set_idling(0);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // passthrough: empty pull, held byte, second push refused, unused command
    write_reg(CFG_PASSTHROUGH, 5'd1);
    write_reg(CFG_MAX_BITS, 5'd31);
    write_reg(CFG_BLOCK_MODE, 5'd0);
    send_req(CMD_PULL, 8'h00);
    send_req(CMD_PUSH, 8'h00);
    send_req(CMD_PUSH, 8'hff);
    send_req(CMD_PULL, 8'h00);
    send_req(CMD_PULL, 8'hff);
    send_req(CMD_PUSH, 8'hff);
    send_req(CMD_PULL, 8'h00);
    send_req(cmd_e'(2'd3), 8'hff);
    send_req(CMD_PUSH, 8'ha5);
    send_req(cmd_e'(2'd3), 8'h00);
    send_req(CMD_PULL, 8'h00);
    for (int i = 0; i < 120; i++) begin
      set_idling(i / 30);
      r = $urandom_range(99);
      if (r < 45) send_req(CMD_PUSH, 8'($urandom));
      else if (r < 90) send_req(CMD_PULL, 8'($urandom));
      else send_req(cmd_e'(2'd3), 8'($urandom));
    end
    send_req(CMD_PULL, 8'h00);
    settle();

    // compressed stream
    set_idling(0);
    write_reg(CFG_PASSTHROUGH, 5'd0);
    write_reg(CFG_BLOCK_MODE, 5'd1);
    write_reg(CFG_MAX_BITS, 5'd10);
    while (g_codes < StreamCodes) begin
      set_idling((g_codes / 110) % 4);
      if (g_codes >= 220 && !held) begin
        hold_ask = hold_ask + 1;
        held     = 1;
      end
      if (need_cnt != need_done) begin
        settle();
        need_done = need_cnt;
        take_group(n);
        for (int i = 0; i < int'(n); i++) send_req(CMD_PUSH, grp_bytes.pop_front());
        // group already full
        if ($urandom_range(7) == 0) send_req(CMD_PUSH, 8'($urandom));
      end else if ($urandom_range(39) == 0) begin
        send_req(cmd_e'(2'd3), 8'($urandom));
      end else if ($urandom_range(29) == 0) begin
        // push while a group is being decoded
        settle();
        if (last_st == ST_BYTE && need_cnt == need_done) send_req(CMD_PUSH, 8'($urandom));
      end else begin
        send_req(CMD_PULL, 8'($urandom));
      end
    end

    // short last group, then end of input
    while (need_cnt == need_done) send_req(CMD_PULL, 8'h00);
    settle();
    need_done = need_cnt;
    take_group(n);
    k = $urandom_range(n - 1);
    for (int i = 0; i < int'(n); i++) begin
      if (i < int'(k)) send_req(CMD_PUSH, grp_bytes.pop_front());
      else void'(grp_bytes.pop_front());
    end
    send_req(CMD_END, 8'h00);
    send_req(CMD_END, 8'hff);
    send_req(CMD_PUSH, 8'h3c);
    do begin
      send_req(CMD_PULL, 8'h00);
      settle();
    end while (last_st != ST_END);
    send_req(CMD_PULL, 8'h00);
    settle();

    // after end of data, under other settings
    write_reg(CFG_MAX_BITS, 5'd0);
    write_reg(CFG_BLOCK_MODE, 5'd0);
    for (int i = 0; i < 20; i++) send_req(cmd_e'(2'($urandom)), 8'($urandom));
    settle();
    write_reg(CFG_PASSTHROUGH, 5'd1);
    write_reg(CFG_MAX_BITS, 5'd16);
    for (int i = 0; i < 20; i++) send_req(cmd_e'(2'($urandom)), 8'($urandom));
    settle();
    repeat (50) @(posedge clk_i);

    if (errors == 0 && pending == 0) begin
      $display("[lzw_compress_decoder] OK");
    end else begin
      $display("[lzw_compress_decoder] ERROR");
    end
    $finish;
  end

endmodule

>>> lzw_compress_decoder.f
rtl/lzwd_pkg.sv
rtl/lzwd_ctrl.sv
rtl/lzwd_dp.sv
rtl/lzw_compress_decoder.sv
dv/lzwd_checker.sv
dv/testbench.sv
